FILE: rtl/core/timestamped_log_ring_buffer_top_assert.svh
// Assertion macros shared by the log ring buffer modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef TIMESTAMPED_LOG_RING_BUFFER_TOP_ASSERT_SVH
`define TIMESTAMPED_LOG_RING_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TLRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define TLRB_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/tlrb_pkg.sv
// Types, constants and helper functions of the log ring buffer.
// No dependencies; imported by every module of the block but tlrb_ram.
`default_nettype none

package tlrb_pkg;

  // Ring depth; must be a power of two (slot is the low sequence bits).
  localparam int LOG_DEPTH   = 8192;
  localparam int LOG_AW      = $clog2(LOG_DEPTH);
  localparam int MAX_READ    = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] LOG_DEPTH_W = 32'(LOG_DEPTH);
  localparam logic [6:0]  MAX_READ_W  = 7'(MAX_READ);

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Characters
  localparam logic [7:0] CH_OPEN    = 8'h5B;
  localparam logic [7:0] CH_CLOSE   = 8'h5D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [4:0] CONV_LAST  = 5'd31;
  localparam logic [2:0] STAMP_LAST = 3'd6;

  typedef struct packed {
    logic        operation;
    logic [7:0]  byte_in;
    logic [31:0] time_ms;
    logic [31:0] from_seq;
    logic [6:0]  max_bytes;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [31:0] byte_seq;
    logic        byte_valid;
    logic [31:0] next_seq;
    logic        last;
  } res_t;

  // Classified item between front and back. digits[4] is the ten-thousands digit.
  typedef struct packed {
    logic            op;
    logic [7:0]      byte_in;
    logic            stamp;
    logic [4:0][3:0] digits;
    logic [31:0]     from_seq;
    logic [6:0]      limit;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Subtrahend of one conversion step. Steps 0..15 reduce modulo 100000
  // (100000 shifted by 15 down to 0); steps 16..31 take out four decimal
  // digits, four binary weights each (8c, 4c, 2c, c).
  function automatic logic [31:0] conv_sub(input logic [4:0] step);
    logic [31:0] w;
    begin
      if (!step[4]) begin
        w = 32'd100000 << (~step[3:0]);
      end else begin
        case (step[3:2])
          2'd0:    w = 32'd10000;
          2'd1:    w = 32'd1000;
          2'd2:    w = 32'd100;
          default: w = 32'd10;
        endcase
        w = w << (~step[1:0]);
      end
      conv_sub = w;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tlrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tlrb_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlrb_queue.sv
// Two-entry queue of classified items between front and back.
// Depends on tlrb_pkg.
`default_nettype none

module tlrb_queue import tlrb_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t data_i,
  input  wire logic     pop_i,
  output q_entry_t      head_o,
  output q_status_t     status_o
);

  q_entry_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wptr_q, wptr_d;
  logic [QUEUE_AW-1:0]   rptr_q, rptr_d;
  logic [QUEUE_CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + QUEUE_AW'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + QUEUE_AW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QUEUE_CW'(1);
      2'b01:   cnt_d = cnt_q - QUEUE_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign head_o         = mem_q[rptr_q];
  assign status_o.full  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  `include "timestamped_log_ring_buffer_top_assert.svh"

  `TLRB_ASSERT_NEVER(a_push_full, push_i && status_o.full, "push into full queue")
  `TLRB_ASSERT_NEVER(a_pop_empty, pop_i && status_o.empty, "pop from empty queue")
  `TLRB_ASSERT_NEXT(a_cnt_up, push_i && !pop_i, cnt_q == $past(cnt_q) + QUEUE_CW'(1), "queue count did not advance")

endmodule

`default_nettype wire

FILE: rtl/core/tlrb_front.sv
// Front end: takes commands, tracks line starts, saturates the read limit
// and converts the time stamp to five decimal digits. Depends on tlrb_pkg.
`default_nettype none

module tlrb_front import tlrb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire cmd_t      cmd_i,
  output logic           busy_o,
  input  wire q_status_t status_i,
  output logic           push_o,
  output q_entry_t       entry_o
);

  logic        hold_q, hold_d;
  logic        conv_q, conv_d;
  logic        stamp_q, stamp_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] rem_q, rem_d;
  q_entry_t    ent_q, ent_d;

  logic        accept;
  logic [31:0] sub;
  logic        ge;
  logic [2:0]  dig_idx;
  logic [1:0]  bit_idx;

  assign push_o  = hold_q & ~conv_q & ~status_i.full;
  assign busy_o  = hold_q & ~push_o;
  assign accept  = start_i & ~busy_o;
  assign entry_o = ent_q;

  assign sub     = conv_sub(step_q);
  assign ge      = (rem_q >= sub);
  assign dig_idx = 3'd4 - {1'b0, step_q[3:2]};
  assign bit_idx = ~step_q[1:0];

  always_comb begin
    hold_d  = hold_q;
    conv_d  = conv_q;
    stamp_d = stamp_q;
    step_d  = step_q;
    rem_d   = rem_q;
    ent_d   = ent_q;

    // One compare and subtract per step
    if (hold_q && conv_q) begin
      if (ge) begin
        rem_d = rem_q - sub;
      end
      if (step_q[4]) begin
        ent_d.digits[dig_idx][bit_idx] = ge;
      end
      step_d = step_q + 5'd1;
      if (step_q == CONV_LAST) begin
        conv_d           = 1'b0;
        ent_d.digits[0]  = rem_d[3:0];
      end
    end

    if (push_o) begin
      hold_d = 1'b0;
    end

    if (accept) begin
      hold_d         = 1'b1;
      ent_d.op       = cmd_i.operation;
      ent_d.byte_in  = cmd_i.byte_in;
      ent_d.from_seq = cmd_i.from_seq;
      ent_d.limit    = (cmd_i.max_bytes > MAX_READ_W) ? MAX_READ_W : cmd_i.max_bytes;
      ent_d.digits   = '0;
      ent_d.stamp    = (cmd_i.operation == OP_WRITE) & stamp_q;
      rem_d          = cmd_i.time_ms;
      step_d         = '0;
      conv_d         = (cmd_i.operation == OP_WRITE) & stamp_q;
      if (cmd_i.operation == OP_WRITE) begin
        stamp_d = (cmd_i.byte_in == CH_NEWLINE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      conv_q  <= 1'b0;
      stamp_q <= 1'b1;
      step_q  <= '0;
    end else begin
      hold_q  <= hold_d;
      conv_q  <= conv_d;
      stamp_q <= stamp_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    ent_q <= ent_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlrb_back.sv
// Back end: stores prefix and log bytes into the ring and streams reads.
// Depends on tlrb_pkg and tlrb_ram.
`default_nettype none

module tlrb_back import tlrb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire q_status_t status_i,
  input  wire q_entry_t  head_i,
  output logic           pop_o,
  output logic           result_valid_o,
  output res_t           result_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STAMP = 3'd1;
  localparam logic [2:0] S_WBYTE = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;
  localparam logic [2:0] S_AVAIL = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [31:0] wseq_q, wseq_d;
  q_entry_t    entry_q, entry_d;
  logic [31:0] earliest_q, earliest_d;
  logic [31:0] start_q, start_d;
  logic [6:0]  avail_q, avail_d;
  logic [31:0] next_q, next_d;
  logic [31:0] rseq_q, rseq_d;
  logic [6:0]  rcnt_q, rcnt_d;
  logic [2:0]  cnt_q, cnt_d;

  logic        ovalid_q, ovalid_d;
  logic        obv_q, obv_d;
  logic [31:0] oseq_q, oseq_d;
  logic [31:0] onext_q, onext_d;
  logic        olast_q, olast_d;

  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [7:0]  prefix;
  logic [31:0] clamp_lo;
  logic [31:0] diff;
  logic        rlast;

  tlrb_ram #(
    .Width (8),
    .Depth (LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wseq_q[LOG_AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (rseq_q[LOG_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (cnt_q)
      3'd0:    prefix = CH_OPEN;
      3'd1:    prefix = CH_ZERO + {4'd0, entry_q.digits[4]};
      3'd2:    prefix = CH_ZERO + {4'd0, entry_q.digits[3]};
      3'd3:    prefix = CH_ZERO + {4'd0, entry_q.digits[2]};
      3'd4:    prefix = CH_ZERO + {4'd0, entry_q.digits[1]};
      3'd5:    prefix = CH_ZERO + {4'd0, entry_q.digits[0]};
      default: prefix = CH_CLOSE;
    endcase
  end

  assign clamp_lo = (entry_q.from_seq < earliest_q) ? earliest_q : entry_q.from_seq;
  assign diff     = wseq_q - start_q;
  assign rlast    = ((rcnt_q + 7'd1) == avail_q);
  assign pop_o    = (state_q == S_IDLE) & ~status_i.empty;

  always_comb begin
    state_d    = state_q;
    wseq_d     = wseq_q;
    entry_d    = entry_q;
    earliest_d = earliest_q;
    start_d    = start_q;
    avail_d    = avail_q;
    next_d     = next_q;
    rseq_d     = rseq_q;
    rcnt_d     = rcnt_q;
    cnt_d      = cnt_q;
    ovalid_d   = 1'b0;
    obv_d      = obv_q;
    oseq_d     = oseq_q;
    onext_d    = onext_q;
    olast_d    = olast_q;
    ram_we     = 1'b0;
    ram_wdata  = entry_q.byte_in;

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          entry_d    = head_i;
          earliest_d = (wseq_q > LOG_DEPTH_W) ? (wseq_q - LOG_DEPTH_W) : '0;
          cnt_d      = '0;
          if (head_i.op == OP_READ) begin
            state_d = S_CLAMP;
          end else if (head_i.stamp) begin
            state_d = S_STAMP;
          end else begin
            state_d = S_WBYTE;
          end
        end
      end
      S_STAMP: begin
        ram_we    = 1'b1;
        ram_wdata = prefix;
        wseq_d    = wseq_q + 32'd1;
        cnt_d     = cnt_q + 3'd1;
        if (cnt_q == STAMP_LAST) begin
          state_d = S_WBYTE;
        end
      end
      S_WBYTE: begin
        ram_we  = 1'b1;
        wseq_d  = wseq_q + 32'd1;
        state_d = S_IDLE;
      end
      S_CLAMP: begin
        start_d = (clamp_lo > wseq_q) ? wseq_q : clamp_lo;
        state_d = S_AVAIL;
      end
      S_AVAIL: begin
        avail_d = (diff > {25'd0, entry_q.limit}) ? entry_q.limit : diff[6:0];
        state_d = S_FIN;
      end
      S_FIN: begin
        next_d = start_q + {25'd0, avail_q};
        rseq_d = start_q;
        rcnt_d = '0;
        if (avail_q == '0) begin
          // Empty read: one marker result
          ovalid_d = 1'b1;
          obv_d    = 1'b0;
          oseq_d   = start_q;
          onext_d  = next_d;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        ovalid_d = 1'b1;
        obv_d    = 1'b1;
        oseq_d   = rseq_q;
        onext_d  = next_q;
        olast_d  = rlast;
        rseq_d   = rseq_q + 32'd1;
        rcnt_d   = rcnt_q + 7'd1;
        if (rlast) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wseq_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wseq_q   <= wseq_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q    <= entry_d;
    earliest_q <= earliest_d;
    start_q    <= start_d;
    avail_q    <= avail_d;
    next_q     <= next_d;
    rseq_q     <= rseq_d;
    rcnt_q     <= rcnt_d;
    cnt_q      <= cnt_d;
    obv_q      <= obv_d;
    oseq_q     <= oseq_d;
    onext_q    <= onext_d;
    olast_q    <= olast_d;
  end

  assign result_valid_o      = ovalid_q;
  assign result_o.out_byte   = obv_q ? ram_rdata : 8'h00;
  assign result_o.byte_seq   = oseq_q;
  assign result_o.byte_valid = obv_q;
  assign result_o.next_seq   = onext_q;
  assign result_o.last       = olast_q;

  `include "timestamped_log_ring_buffer_top_assert.svh"

  `TLRB_ASSERT_NEXT(a_seq_step, result_valid_o && !result_o.last, result_valid_o && (result_o.byte_seq == $past(result_o.byte_seq) + 32'd1), "read stream broke sequence")
  `TLRB_ASSERT_IMP(a_empty_form, result_valid_o && !result_o.byte_valid, result_o.last && (result_o.byte_seq == result_o.next_seq), "malformed empty read")
  `TLRB_ASSERT_NEVER(a_wr_in_read, ram_we && (ovalid_q || state_q == S_READ || state_q == S_FIN), "ring written during read")

endmodule

`default_nettype wire

FILE: rtl/core/timestamped_log_ring_buffer_top.sv
// Top level of the time-stamped log ring buffer.
// Depends on tlrb_pkg, tlrb_front, tlrb_queue, tlrb_back (and tlrb_ram).
//
//   channel   dir  handshake              payload
//   command   in   start & !busy          cmd_i    (cmd_t)
//   result    out  result_valid_o strobe  result_o (res_t)
//
// A plain write skips conversion; the back stores it in S_WBYTE. A write that
// opens a line converts the time in the front (one compare and subtract per
// cycle), then the back writes the prefix and the byte (the single RAM write
// port stores one byte per cycle). A read clamps its range in S_CLAMP, S_AVAIL
// and S_FIN, then streams one byte per cycle out of the RAM's registered read.
// Reset clears control state only; the ring contents stay unknown until written.
// Results are strobes for one cycle; the receiver cannot stall them.
`default_nettype none

module timestamped_log_ring_buffer_top import tlrb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire cmd_t cmd_i,
  output logic      busy,
  output logic      result_valid_o,
  output res_t      result_o
);

  // Front to queue
  logic      push;
  q_entry_t  push_entry;
  // Queue to back
  logic      pop;
  q_entry_t  head;
  q_status_t q_status;

  // Accept commands, convert the stamp, hold the item until the queue has room
  tlrb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cmd_i    (cmd_i),
    .busy_o   (busy),
    .status_i (q_status),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // Decouple the two sides: keep items in order
  tlrb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // Store bytes, advance the sequence counter, stream reads
  tlrb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .status_i       (q_status),
    .head_i         (head),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_timestamped_log_ring_buffer_top.sv
// Self-checking testbench for timestamped_log_ring_buffer_top.
// Depends on tlrb_pkg and the RTL from the top down; a shadow ring predicts untyped read-back.
`default_nettype none

module tb_timestamped_log_ring_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tlrb_pkg::*;

  // Run bounds. The slowest transfers are a line-opening write (converted in the
  // front, then stored byte by byte in the back) and a 64-byte read; with idling
  // the whole run stays far below the limit.
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RAND_ITEMS   = 45;   // per idling phase
  localparam int MAX_REPORTS  = 10;

  logic clk_i;
  logic rst_ni;
  logic start;
  cmd_t cmd_i;
  logic busy;
  logic result_valid_o;
  res_t result_o;

  timestamped_log_ring_buffer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .cmd_i          (cmd_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // One row of the directed table. Where has_res is set the single result is
  // typed in; otherwise the shadow ring supplies the expected bytes.
  typedef struct {
    cmd_t cmd;
    bit   has_res;
    res_t res;
  } stim_row_t;

  stim_row_t directed_rows[$];

  // Shadow copy of the log store and its control state.
  logic [7:0]  shadow_ring [LOG_DEPTH];
  logic [31:0] shadow_seq;
  bit          shadow_stamp_due;

  // Read-back bytes still owed by the block, oldest first.
  res_t read_back_q[$];

  int idle_pct;
  int mismatch_count;
  int results_checked;
  int writes_sent;
  int reads_sent;
  int cycle_count = 0;

  // Clock: 8 ns period.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timestamped_log_ring_buffer_top verification failed");
      $finish;
    end
  end

  // Store one byte at the next sequence number and advance it.
  function automatic void shadow_store(input logic [7:0] b);
    shadow_ring[shadow_seq[LOG_AW-1:0]] = b;
    shadow_seq = shadow_seq + 32'd1;
  endfunction

  // Apply one accepted transfer to the shadow ring. For a read, queue the
  // expected bytes unless the caller typed the result in by hand.
  function automatic void apply_log_cmd(input cmd_t c, input bit queue_results);
    logic [31:0] t;
    logic [31:0] oldest;
    logic [31:0] first;
    logic [31:0] count;
    logic [31:0] limit;
    logic [31:0] next;
    logic [31:0] seq;
    res_t r;
    if (c.operation == OP_WRITE) begin
      if (shadow_stamp_due) begin
        t = c.time_ms;
        shadow_store(CH_OPEN);
        shadow_store(8'(CH_ZERO + (t / 32'd10000) % 32'd10));
        shadow_store(8'(CH_ZERO + (t / 32'd1000) % 32'd10));
        shadow_store(8'(CH_ZERO + (t / 32'd100) % 32'd10));
        shadow_store(8'(CH_ZERO + (t / 32'd10) % 32'd10));
        shadow_store(8'(CH_ZERO + t % 32'd10));
        shadow_store(CH_CLOSE);
      end
      shadow_store(c.byte_in);
      shadow_stamp_due = (c.byte_in == CH_NEWLINE);
      return;
    end
    // Clamp the start into the retained window [oldest, shadow_seq].
    oldest = (shadow_seq > LOG_DEPTH_W) ? shadow_seq - LOG_DEPTH_W : 32'd0;
    first  = c.from_seq;
    if (first < oldest) first = oldest;
    if (first > shadow_seq) first = shadow_seq;
    limit = (c.max_bytes > MAX_READ_W) ? 32'(MAX_READ) : 32'(c.max_bytes);
    count = shadow_seq - first;
    if (count > limit) count = limit;
    next = first + count;
    if (!queue_results) return;
    if (count == 32'd0) begin
      r = '{out_byte: 8'h00, byte_seq: first, byte_valid: 1'b0, next_seq: next, last: 1'b1};
      read_back_q.push_back(r);
      return;
    end
    for (logic [31:0] i = 0; i < count; i++) begin
      seq = first + i;
      r = '{out_byte: shadow_ring[seq[LOG_AW-1:0]], byte_seq: seq, byte_valid: 1'b1,
            next_seq: next, last: (i + 32'd1 == count)};
      read_back_q.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic op, input logic [7:0] b, input logic [31:0] t,
                                  input logic [31:0] from, input logic [6:0] maxb,
                                  input bit has, input res_t r);
    stim_row_t row;
    row.cmd     = '{operation: op, byte_in: b, time_ms: t, from_seq: from, max_bytes: maxb};
    row.has_res = has;
    row.res     = r;
    directed_rows.push_back(row);
  endfunction

  // Present one command, inserting random idle cycles first, and hold it until
  // the transfer completes. The expectation is booked at the accepting edge.
  task automatic send_cmd(input cmd_t c, input bit has_res, input res_t typed);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    apply_log_cmd(c, !has_res);
    if (has_res) read_back_q.push_back(typed);
    if (c.operation == OP_WRITE) writes_sent++;
    else reads_sent++;
  endtask

  // Random command, biased toward reads that land near the window edges.
  task automatic make_random_cmd(output cmd_t c);
    logic [31:0] oldest;
    oldest = (shadow_seq > LOG_DEPTH_W) ? shadow_seq - LOG_DEPTH_W : 32'd0;
    c.byte_in   = ($urandom_range(0, 4) == 0) ? CH_NEWLINE : 8'($urandom_range(0, 255));
    c.time_ms   = $urandom();
    c.from_seq  = $urandom();
    c.max_bytes = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 64));
    if ($urandom_range(0, 99) < 45) begin
      c.operation = OP_WRITE;
    end else begin
      c.operation = OP_READ;
      case ($urandom_range(0, 5))
        0: c.from_seq = shadow_seq - 32'($urandom_range(0, 80));
        1: ; // keep the fully random start
        2: c.from_seq = oldest - 32'($urandom_range(0, 40));
        3: c.from_seq = shadow_seq + 32'($urandom_range(0, 5));
        4: c.from_seq = 32'd0;
        default: c.from_seq = oldest + 32'($urandom_range(0, 100));
      endcase
    end
  endtask

  // Compare one strobed result with the oldest outstanding expectation.
  task automatic check_result(input res_t got);
    res_t want;
    bit   bad;
    if (read_back_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("ERROR: unexpected result byte=%h seq=%0d valid=%b next=%0d last=%b",
                 got.out_byte, got.byte_seq, got.byte_valid, got.next_seq, got.last);
      return;
    end
    want = read_back_q.pop_front();
    results_checked++;
    bad = (got.out_byte !== want.out_byte) || (got.byte_seq !== want.byte_seq) ||
          (got.byte_valid !== want.byte_valid) || (got.next_seq !== want.next_seq) ||
          (got.last !== want.last);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display({"ERROR: exp byte=%h seq=%0d valid=%b next=%0d last=%b",
                  " / got byte=%h seq=%0d valid=%b next=%0d last=%b"},
                 want.out_byte, want.byte_seq, want.byte_valid, want.next_seq, want.last,
                 got.out_byte, got.byte_seq, got.byte_valid, got.next_seq, got.last);
    end
  endtask

  // Results are one-cycle strobes; sample them at the edge that ends the cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) check_result(result_o);
  end

  initial begin
    cmd_t c;
    res_t none;
    none             = '0;
    mismatch_count   = 0;
    results_checked  = 0;
    writes_sent      = 0;
    reads_sent       = 0;
    idle_pct         = 33;
    shadow_seq       = 32'd0;
    shadow_stamp_due = 1'b1;
    rst_ni           = 1'b0;
    start            = 1'b0;
    cmd_i            = '0;

    // Directed table. Sequence layout after the writes below:
    //   0..10  "[12345]A", 00, FF, newline
    //   11..19 "[67295]Z", newline   (time 2^32-1 wraps to 67295)
    //   20..28 "[00000]", 80, newline
    //   29..36 "[99999]", 7F         (line left open)
    // Reads on an empty log: both clamps pull the start to zero.
    add_row(OP_READ, 8'h00, 32'd0, 32'd0, 7'd5, 1'b1,
            '{8'h00, 32'd0, 1'b0, 32'd0, 1'b1});
    add_row(OP_READ, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 1'b1,
            '{8'h00, 32'd0, 1'b0, 32'd0, 1'b1});
    add_row(OP_WRITE, 8'h41, 32'd12345, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, 8'h00, 32'd0, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd127, 1'b0, none);
    add_row(OP_WRITE, CH_NEWLINE, 32'd5, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_READ, 8'h00, 32'd0, 32'd0, 7'd1, 1'b1,
            '{CH_OPEN, 32'd0, 1'b1, 32'd1, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'd1, 7'd1, 1'b1,
            '{8'h31, 32'd1, 1'b1, 32'd2, 1'b1});
    add_row(OP_WRITE, 8'h5A, 32'hFFFF_FFFF, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, CH_NEWLINE, 32'd0, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, 8'h80, 32'd0, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, CH_NEWLINE, 32'd0, 32'd0, 7'd0, 1'b0, none);
    add_row(OP_WRITE, 8'h7F, 32'd99999, 32'd0, 7'd0, 1'b0, none);
    // Zero limit, future start, last byte with saturated limit, nothing new, a stamp digit, far start.
    add_row(OP_READ, 8'h00, 32'd0, 32'd0, 7'd0, 1'b1,
            '{8'h00, 32'd0, 1'b0, 32'd0, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'hFFFF_FFFF, 7'd10, 1'b1,
            '{8'h00, 32'd37, 1'b0, 32'd37, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'd36, 7'd127, 1'b1,
            '{8'h7F, 32'd36, 1'b1, 32'd37, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'd37, 7'd64, 1'b1,
            '{8'h00, 32'd37, 1'b0, 32'd37, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'd12, 7'd1, 1'b1,
            '{8'h36, 32'd12, 1'b1, 32'd13, 1'b1});
    add_row(OP_READ, 8'h00, 32'd0, 32'h8000_0000, 7'd64, 1'b1,
            '{8'h00, 32'd37, 1'b0, 32'd37, 1'b1});
    // Multi-byte reads come from the shadow ring.
    add_row(OP_READ, 8'h00, 32'd0, 32'd0, 7'd64, 1'b0, none);
    add_row(OP_READ, 8'h00, 32'd0, 32'd0, 7'd127, 1'b0, none);
    add_row(OP_READ, 8'h00, 32'd0, 32'd10, 7'd20, 1'b0, none);
    add_row(OP_READ, 8'h00, 32'd0, 32'd5, 7'd65, 1'b0, none);

    // Hold reset, then release it on an edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_cmd(directed_rows[i].cmd, directed_rows[i].has_res, directed_rows[i].res);

    // Random phase with the sender idling a third of the time.
    repeat (RAND_ITEMS) begin
      make_random_cmd(c);
      send_cmd(c, 1'b0, none);
    end

    // Sender idles heavily, then not at all.
    idle_pct = 70;
    repeat (RAND_ITEMS) begin
      make_random_cmd(c);
      send_cmd(c, 1'b0, none);
    end
    idle_pct = 0;
    repeat (RAND_ITEMS) begin
      make_random_cmd(c);
      send_cmd(c, 1'b0, none);
    end
    start <= 1'b0;

    // Drain outstanding read-back, then let any trailing write settle.
    while (read_back_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d writes and %0d reads, %0d bytes logged",
             writes_sent, reads_sent, shadow_seq);
    $display("Checked %0d read results, %0d mismatches", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("timestamped_log_ring_buffer_top verification clean");
    end else begin
      $display("timestamped_log_ring_buffer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/tlrb_pkg.sv
rtl/core/tlrb_ram.sv
rtl/core/tlrb_queue.sv
rtl/core/tlrb_front.sv
rtl/core/tlrb_back.sv
rtl/core/timestamped_log_ring_buffer_top.sv
tb/sv/tb_timestamped_log_ring_buffer_top.sv
